// ===== rtl/core/clru_pkg.sv =====
// shared constants and types for the cost-bounded lru cache
package clru_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COST_BITS  = 24;
  localparam int TOT_BITS   = COST_BITS + 1;
  localparam int ACT_BITS   = 3;

  localparam logic [COST_BITS-1:0] BUDGET_RESET = COST_BITS'(10000000);

  localparam logic [ACT_BITS-1:0] ACT_GET      = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_CONTAINS = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_INSERT   = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE   = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_CLEAR    = 3'd4;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [COST_BITS-1:0]  cost;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== rtl/core/clru_ram.sv =====
// simple dual-port memory with registered read data
module clru_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cost_bounded_lru_cache_unit.sv =====
// top level of the cost-bounded lru cache: sequencer, state and memories
// clear and unused actions finish in idle without busy; others scan every entry, then
// decide; a rank pass follows a get hit or a change; an accepted insert then evicts
// the oldest entry while over budget with more than one left; one operation at a time;
// busy stays high until done, a one-cycle strobe; the receiver cannot stall
// synchronous reset empties the cache and loads the default budget
module cost_bounded_lru_cache_unit
  import clru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACT_BITS-1:0]   action,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic [VALUE_BITS-1:0] payload,
  input  logic [COST_BITS-1:0]  item_cost,
  output logic                  done,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] payload_out,
  output logic                  accepted,
  output logic [COST_BITS-1:0]  used_cost,
  output logic [6:0]            entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COST_BITS-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_RANK  = 3'd3;
  localparam logic [2:0] S_ECHK  = 3'd4;
  localparam logic [2:0] S_EVICT = 3'd5;
  localparam logic [2:0] S_EDROP = 3'd6;

  logic [2:0]            state;
  logic [COST_BITS-1:0]  budget;
  logic [ENTRIES-1:0]    valid_vec;
  logic [TOT_BITS-1:0]   total;
  logic [CNT_BITS-1:0]   count;

  logic [ACT_BITS-1:0]   act;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [COST_BITS-1:0]  cost_r;

  logic [IDX_BITS:0]     scan_idx;
  logic                  p_vld;
  logic [IDX_BITS-1:0]   p_idx;

  logic                  f_hit;
  logic [IDX_BITS-1:0]   f_idx;
  logic [IDX_BITS-1:0]   f_rank;
  logic [COST_BITS-1:0]  f_cost;
  logic [VALUE_BITS-1:0] f_val;
  logic                  f_free_ok;
  logic [IDX_BITS-1:0]   f_free;
  logic [IDX_BITS-1:0]   f_old;
  logic [COST_BITS-1:0]  f_old_cost;

  logic                  mode_touch;
  logic [CNT_BITS-1:0]   thr;
  logic [IDX_BITS-1:0]   tgt;
  logic                  post_evict;

  logic                  hit_o;
  logic [VALUE_BITS-1:0] pay_o;
  logic                  acc_o;

  entry_t                ent_rd;
  entry_t                ent_wd;
  logic                  ent_we;
  logic [IDX_BITS-1:0]   rank_rd;
  logic [IDX_BITS-1:0]   rank_wd;
  logic                  rank_we;

  logic                  ins_ok;
  logic [IDX_BITS-1:0]   ins_slot;
  logic [CNT_BITS-1:0]   ins_thr;
  logic [TOT_BITS-1:0]   ins_total;
  logic [CNT_BITS-1:0]   ins_count;
  logic                  scan_more;
  logic                  p_last;
  logic                  cur_valid;
  logic [CNT_BITS-1:0]   rank_ext;

  assign busy        = (state != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign hit         = hit_o;
  assign payload_out = pay_o;
  assign accepted    = acc_o;
  assign used_cost   = total[COST_BITS-1:0];
  assign entry_count = 7'(count);

  assign scan_more = (scan_idx < (IDX_BITS+1)'(ENTRIES));
  assign p_last    = p_vld && (p_idx == IDX_BITS'(ENTRIES - 1));
  assign cur_valid = valid_vec[p_idx];
  assign rank_ext  = CNT_BITS'(rank_rd);

  always_comb begin
    ins_ok    = (cost_r <= budget);
    ins_slot  = f_free;
    ins_thr   = count;
    ins_total = total + TOT_BITS'(cost_r);
    ins_count = count + CNT_BITS'(1);
    if (f_hit) begin
      ins_slot  = f_idx;
      ins_thr   = CNT_BITS'(f_rank);
      ins_total = total - TOT_BITS'(f_cost) + TOT_BITS'(cost_r);
      ins_count = count;
    end else if (count == CNT_BITS'(ENTRIES)) begin
      ins_slot  = f_old;
      ins_thr   = count - CNT_BITS'(1);
      ins_total = total - TOT_BITS'(f_old_cost) + TOT_BITS'(cost_r);
      ins_count = count;
    end
  end

  assign ent_we = (state == S_DEC) && (act == ACT_INSERT) && ins_ok;
  always_comb begin
    ent_wd.key   = key_r;
    ent_wd.value = val_r;
    ent_wd.cost  = cost_r;
  end

  always_comb begin
    rank_we = (state == S_RANK) && p_vld && cur_valid;
    rank_wd = rank_rd;
    if (mode_touch) begin
      if (p_idx == tgt) begin
        rank_wd = '0;
      end else if (rank_ext < thr) begin
        rank_wd = rank_rd + IDX_BITS'(1);
      end
    end else if (rank_ext > thr) begin
      rank_wd = rank_rd - IDX_BITS'(1);
    end
  end

  clru_ram #(.DEPTH(ENTRIES), .DW(ENTRY_BITS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ins_slot),
    .wdata (ent_wd),
    .raddr (scan_idx[IDX_BITS-1:0]),
    .rdata (ent_rd)
  );

  clru_ram #(.DEPTH(ENTRIES), .DW(IDX_BITS)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (p_idx),
    .wdata (rank_wd),
    .raddr (scan_idx[IDX_BITS-1:0]),
    .rdata (rank_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      budget    <= BUDGET_RESET;
      valid_vec <= '0;
      total     <= '0;
      count     <= '0;
      done      <= 1'b0;
      p_vld     <= 1'b0;
      scan_idx  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        budget <= cfg_data;
      end
      if (state == S_FIND || state == S_RANK || state == S_EVICT) begin
        if (scan_more) begin
          scan_idx <= scan_idx + (IDX_BITS+1)'(1);
          p_vld    <= 1'b1;
          p_idx    <= scan_idx[IDX_BITS-1:0];
        end else begin
          p_vld <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act       <= action;
            key_r     <= lookup_key;
            val_r     <= payload;
            cost_r    <= item_cost;
            hit_o     <= 1'b0;
            pay_o     <= '0;
            acc_o     <= 1'b0;
            f_hit     <= 1'b0;
            f_free_ok <= 1'b0;
            scan_idx  <= '0;
            p_vld     <= 1'b0;
            case (action) inside
              ACT_GET, ACT_CONTAINS, ACT_INSERT, ACT_REMOVE: state <= S_FIND;
              ACT_CLEAR: begin
                valid_vec <= '0;
                total     <= '0;
                count     <= '0;
                done      <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_FIND: begin
          if (p_vld) begin
            if (cur_valid && !f_hit && ent_rd.key == key_r) begin
              f_hit  <= 1'b1;
              f_idx  <= p_idx;
              f_rank <= rank_rd;
              f_cost <= ent_rd.cost;
              f_val  <= ent_rd.value;
            end
            if (!cur_valid && !f_free_ok) begin
              f_free_ok <= 1'b1;
              f_free    <= p_idx;
            end
            if (cur_valid && rank_ext + CNT_BITS'(1) == count) begin
              f_old      <= p_idx;
              f_old_cost <= ent_rd.cost;
            end
          end
          if (p_last) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          hit_o      <= f_hit;
          scan_idx   <= '0;
          p_vld      <= 1'b0;
          tgt        <= f_idx;
          thr        <= CNT_BITS'(f_rank);
          mode_touch <= 1'b0;
          post_evict <= 1'b0;
          state      <= S_IDLE;
          case (act)
            ACT_GET: begin
              if (f_hit) begin
                pay_o      <= f_val;
                mode_touch <= 1'b1;
                state      <= S_RANK;
              end else begin
                done <= 1'b1;
              end
            end
            ACT_INSERT: begin
              if (ins_ok) begin
                acc_o               <= 1'b1;
                valid_vec[ins_slot] <= 1'b1;
                total               <= ins_total;
                count               <= ins_count;
                tgt                 <= ins_slot;
                thr                 <= ins_thr;
                mode_touch          <= 1'b1;
                post_evict          <= 1'b1;
                state               <= S_RANK;
              end else if (f_hit) begin
                valid_vec[f_idx] <= 1'b0;
                total <= (total >= TOT_BITS'(f_cost)) ? total - TOT_BITS'(f_cost) : '0;
                count <= count - CNT_BITS'(1);
                state <= S_RANK;
              end else begin
                done <= 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (f_hit) begin
                valid_vec[f_idx] <= 1'b0;
                total <= (total >= TOT_BITS'(f_cost)) ? total - TOT_BITS'(f_cost) : '0;
                count <= count - CNT_BITS'(1);
                state <= S_RANK;
              end else begin
                done <= 1'b1;
              end
            end
            default: done <= 1'b1;
          endcase
        end
        S_RANK: begin
          if (p_last) begin
            if (post_evict) begin
              state <= S_ECHK;
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end
        end
        S_ECHK: begin
          scan_idx <= '0;
          p_vld    <= 1'b0;
          if (total > TOT_BITS'(budget) && count > CNT_BITS'(1)) begin
            state <= S_EVICT;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_EVICT: begin
          if (p_vld && cur_valid && rank_ext + CNT_BITS'(1) == count) begin
            f_old      <= p_idx;
            f_old_cost <= ent_rd.cost;
          end
          if (p_last) begin
            state <= S_EDROP;
          end
        end
        S_EDROP: begin
          valid_vec[f_old] <= 1'b0;
          total <= (total >= TOT_BITS'(f_old_cost)) ? total - TOT_BITS'(f_old_cost) : '0;
          count <= count - CNT_BITS'(1);
          state <= S_ECHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/clru_result_checker.sv =====
// result checker for the cost-bounded lru cache: predicts each transfer and compares
module clru_result_checker
  import clru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [ACT_BITS-1:0]   action,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic [VALUE_BITS-1:0] payload,
  input  logic [COST_BITS-1:0]  item_cost,
  input  logic                  done,
  input  logic                  hit,
  input  logic [VALUE_BITS-1:0] payload_out,
  input  logic                  accepted,
  input  logic [COST_BITS-1:0]  used_cost,
  input  logic [6:0]            entry_count,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [COST_BITS-1:0]  cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic                  hit;
    logic [VALUE_BITS-1:0] value;
    logic                  stored;
    logic [COST_BITS-1:0]  cost_sum;
    logic [6:0]            count;
  } cache_reply_t;

  logic [KEY_BITS-1:0]   held_key   [ENTRIES];
  logic [VALUE_BITS-1:0] held_value [ENTRIES];
  logic [COST_BITS-1:0]  held_cost  [ENTRIES];
  bit                    held_valid [ENTRIES];
  int                    age        [ENTRIES];
  int                    cost_total;
  int                    held_count;
  int                    budget;
  cache_reply_t          expected_replies [$];

  function automatic int find_key(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (held_valid[i] && held_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_oldest();
    for (int i = 0; i < ENTRIES; i++)
      if (held_valid[i] && age[i] + 1 == held_count) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int e);
    int r;
    r = age[e];
    for (int i = 0; i < ENTRIES; i++)
      if (held_valid[i] && age[i] > r) age[i]--;
    held_valid[e] = 0;
    age[e] = 0;
    cost_total = (cost_total >= int'(held_cost[e])) ? cost_total - int'(held_cost[e]) : 0;
    if (held_count > 0) held_count--;
  endfunction

  function automatic void empty_cache();
    for (int i = 0; i < ENTRIES; i++) begin
      held_valid[i] = 0;
      age[i] = 0;
    end
    cost_total = 0;
    held_count = 0;
  endfunction

  function automatic cache_reply_t predict_op(logic [ACT_BITS-1:0] act, logic [KEY_BITS-1:0] k,
                                              logic [VALUE_BITS-1:0] v,
                                              logic [COST_BITS-1:0] c);
    cache_reply_t rep;
    int e;
    int r;
    rep.hit = 0;
    rep.value = '0;
    rep.stored = 0;
    case (act)
      ACT_GET: begin
        e = find_key(k);
        if (e >= 0) begin
          rep.hit = 1;
          rep.value = held_value[e];
          r = age[e];
          for (int i = 0; i < ENTRIES; i++)
            if (held_valid[i] && age[i] < r) age[i]++;
          age[e] = 0;
        end
      end
      ACT_CONTAINS: rep.hit = (find_key(k) >= 0);
      ACT_INSERT: begin
        e = find_key(k);
        if (e >= 0) begin
          rep.hit = 1;
          drop_slot(e);
        end
        if (int'(c) <= budget) begin
          if (held_count >= ENTRIES) begin
            e = find_oldest();
            if (e >= 0) drop_slot(e);
          end
          e = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!held_valid[i] && e < 0) e = i;
          if (e >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (held_valid[i]) age[i]++;
            held_valid[e] = 1;
            age[e] = 0;
            held_key[e] = k;
            held_value[e] = v;
            held_cost[e] = c;
            cost_total += int'(c);
            held_count++;
            rep.stored = 1;
            while (cost_total > budget && held_count > 1) begin
              e = find_oldest();
              if (e < 0) break;
              drop_slot(e);
            end
          end
        end
      end
      ACT_REMOVE: begin
        e = find_key(k);
        if (e >= 0) begin
          rep.hit = 1;
          drop_slot(e);
        end
      end
      ACT_CLEAR: empty_cache();
      default: ;
    endcase
    rep.cost_sum = cost_total[COST_BITS-1:0];
    rep.count = held_count[6:0];
    return rep;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial fail_count = 0;
  assign outstanding = expected_replies.size();

  always @(posedge clk) begin
    cache_reply_t exp_r;
    if (rst) begin
      empty_cache();
      budget = int'(BUDGET_RESET);
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) budget = int'(cfg_data);
      if (done) begin
        if (expected_replies.size() == 0) begin
          $display("%0t result transfer with nothing expected", $time);
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          check_field("hit", exp_r.hit, hit);
          check_field("payload_out", exp_r.value, payload_out);
          check_field("accepted", exp_r.stored, accepted);
          check_field("used_cost", exp_r.cost_sum, used_cost);
          check_field("entry_count", exp_r.count, entry_count);
        end
      end
      if (start && !busy) begin
        exp_r = predict_op(action, lookup_key, payload, item_cost);
        expected_replies = {expected_replies, exp_r};
      end
    end
  end

endmodule

// ===== dv/cost_bounded_lru_cache_unit_test.sv =====
// testbench top for the cost-bounded lru cache: stimulus, clock, reset and verdict
module cost_bounded_lru_cache_unit_test
  import clru_pkg::*;
();

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  start = 0;
  logic                  busy;
  logic [ACT_BITS-1:0]   action = '0;
  logic [KEY_BITS-1:0]   lookup_key = '0;
  logic [VALUE_BITS-1:0] payload = '0;
  logic [COST_BITS-1:0]  item_cost = '0;
  logic                  done;
  logic                  hit;
  logic [VALUE_BITS-1:0] payload_out;
  logic                  accepted;
  logic [COST_BITS-1:0]  used_cost;
  logic [6:0]            entry_count;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [COST_BITS-1:0]  cfg_data = '0;
  int                    fail_count;
  int                    outstanding;
  int                    cycles = 0;
  int                    idle_pct = 0;
  int                    budget_now = int'(BUDGET_RESET);
  logic [KEY_BITS-1:0]   key_pool [80];

  localparam int CYCLE_LIMIT = 3000000;

  cost_bounded_lru_cache_unit uut (.*);

  clru_result_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cost_bounded_lru_cache_unit_test failed");
      $finish;
    end
  end

  task automatic send_op(logic [ACT_BITS-1:0] a, logic [KEY_BITS-1:0] k,
                         logic [VALUE_BITS-1:0] v, logic [COST_BITS-1:0] c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    action <= a;
    lookup_key <= k;
    payload <= v;
    item_cost <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_budget(logic [COST_BITS-1:0] b);
    settle();
    cfg_valid <= 1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    budget_now = int'(b);
  endtask

  function automatic logic [COST_BITS-1:0] pick_cost();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return COST_BITS'($urandom_range(0, budget_now / 40 + 1));
    if (sel < 70) return COST_BITS'($urandom_range(0, budget_now));
    if (sel < 80) return COST_BITS'($urandom);
    if (sel < 88) return COST_BITS'(budget_now);
    if (sel < 94) return COST_BITS'(budget_now + 1);
    return '0;
  endfunction

  task automatic random_ops(int n);
    int sel;
    logic [ACT_BITS-1:0] a;
    logic [KEY_BITS-1:0] k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) a = ACT_INSERT;
      else if (sel < 65) a = ACT_GET;
      else if (sel < 77) a = ACT_CONTAINS;
      else if (sel < 90) a = ACT_REMOVE;
      else if (sel < 92) a = ACT_CLEAR;
      else a = ACT_BITS'($urandom_range(5, 7));
      k = ($urandom_range(9) != 0) ? key_pool[$urandom_range(79)] : $urandom;
      send_op(a, k, $urandom, pick_cost());
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    idle_pct = 24;
    send_op(ACT_GET, 32'h0, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'h0, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'hffffffff, 32'hffffffff, COST_BITS'(BUDGET_RESET));
    send_op(ACT_INSERT, 32'h12345678, 32'h1, 24'hffffff);
    send_op(ACT_GET, 32'hffffffff, 32'h0, 24'h0);
    send_op(ACT_GET, 32'h0, 32'h0, 24'h0);
    send_op(ACT_CONTAINS, 32'hffffffff, 32'h0, 24'h0);
    send_op(ACT_CONTAINS, 32'h5, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'hffffffff, 32'h55, 24'hffffff);
    send_op(ACT_CONTAINS, 32'hffffffff, 32'h0, 24'h0);
    send_op(ACT_REMOVE, 32'h0, 32'h0, 24'h0);
    send_op(ACT_REMOVE, 32'h0, 32'h0, 24'h0);
    send_op(ACT_BITS'(5), 32'h0, 32'hffffffff, 24'hffffff);
    send_op(ACT_BITS'(6), 32'h1, 32'h0, 24'h0);
    send_op(ACT_BITS'(7), 32'h2, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'h10, 32'haa, 24'd6000000);
    send_op(ACT_INSERT, 32'h11, 32'hbb, 24'd4000000);
    send_op(ACT_CLEAR, 32'h10, 32'h0, 24'h0);
    send_op(ACT_CLEAR, 32'h10, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'h20, 32'hcc, 24'd5000);
    send_op(ACT_INSERT, 32'h21, 32'hdd, 24'd5000);
    write_budget(24'd3000);
    send_op(ACT_GET, 32'h20, 32'h0, 24'h0);
    send_op(ACT_INSERT, 32'h22, 32'hee, 24'd100);
    for (int i = 0; i < 70; i++) send_op(ACT_INSERT, 32'h100 + i, $urandom, 24'd1);
    write_budget(BUDGET_RESET);
    random_ops(325);
    write_budget(24'hffffff);
    random_ops(325);
    idle_pct = 56;
    write_budget(24'd0);
    random_ops(300);
    write_budget(24'd500);
    random_ops(325);
    idle_pct = 0;
    write_budget(24'd50000);
    random_ops(325);
    write_budget(24'hffffff);
    random_ops(250);
    settle();
    if (fail_count == 0) begin
      $display("cost_bounded_lru_cache_unit_test passed");
    end else begin
      $display("cost_bounded_lru_cache_unit_test failed");
    end
    $finish;
  end

endmodule

// ===== cost_bounded_lru_cache_unit.f =====
rtl/core/clru_pkg.sv
rtl/core/clru_ram.sv
rtl/core/cost_bounded_lru_cache_unit.sv
dv/clru_result_checker.sv
dv/cost_bounded_lru_cache_unit_test.sv
